// ----- design/ptz_command_frame_decoder_assert.svh -----
// Assertion macros for the checker file of the frame decoder.
`ifndef PTZ_COMMAND_FRAME_DECODER_ASSERT_SVH
`define PTZ_COMMAND_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication, clocked on clk, off while arst_n is low.
`define PCFD_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, clocked on clk, off while arst_n is low.
`define PCFD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/pcfd_pkg.sv -----
// ----------------------------------------------------------------------------
// pcfd_pkg
// Types, codes and the command decode function of the PTZ frame decoder.
// ----------------------------------------------------------------------------
package pcfd_pkg;

	localparam logic [2:0] POS_FIRST = 3'd0;
	localparam logic [2:0] POS_B4    = 3'd3;
	localparam logic [2:0] POS_B7    = 3'd6;
	localparam logic [2:0] POS_LAST  = 3'd7;

	typedef enum logic [2:0] {
		CT_STOP    = 3'd0,
		CT_PTZ     = 3'd1,
		CT_FI      = 3'd2,
		CT_PRESET  = 3'd3,
		CT_PATROL  = 3'd4,
		CT_SCAN    = 3'd5,
		CT_UNKNOWN = 3'd6
	} ctrl_type_t;

	localparam logic [1:0] DIR_NONE = 2'd0;
	localparam logic [1:0] DIR_POS  = 2'd1;
	localparam logic [1:0] DIR_NEG  = 2'd2;

	localparam logic [2:0] SUB_SCAN_SPEED = 3'd3;
	localparam logic [2:0] SUB_NONE       = 3'd5;

	localparam logic [7:0] B4_STOP       = 8'h00;
	localparam logic [3:0] B4_FI_NIBBLE  = 4'h4;
	localparam logic [7:0] B4_PRESET_LO  = 8'h81;
	localparam logic [7:0] B4_PRESET_HI  = 8'h83;
	localparam logic [7:0] B4_PATROL_LO  = 8'h84;
	localparam logic [7:0] B4_PATROL_HI  = 8'h88;
	localparam logic [7:0] B4_SCAN       = 8'h89;
	localparam logic [7:0] B4_SCAN_SPEED = 8'h8a;
	localparam logic [7:0] SCAN_SUB_MAX  = 8'h02;

	typedef struct packed {
		logic [2:0]  control_type;
		logic [1:0]  zoom_dir;
		logic [1:0]  tilt_dir;
		logic [1:0]  pan_dir;
		logic [1:0]  iris_dir;
		logic [1:0]  focus_dir;
		logic [2:0]  sub_command;
		logic [7:0]  byte_five;
		logic [7:0]  byte_six;
		logic [3:0]  zoom_speed;
		logic [11:0] combined_value;
	} result_t;

	// Codes 1 and 2 pass, the unused code 3 reads as none.
	function automatic logic [1:0] dir_code(input logic [1:0] bits);
		return (bits == DIR_POS || bits == DIR_NEG) ? bits : DIR_NONE;
	endfunction

	function automatic result_t decode(input logic [7:0] b4, input logic [7:0] b5,
			input logic [7:0] b6, input logic [7:0] b7);
		result_t    r;
		logic [7:0] diff;
		logic [11:0] comb;
		r            = '0;
		r.sub_command = SUB_NONE;
		comb         = {b7[7:4], b6};
		diff         = 8'h00;
		if (b4 == B4_STOP) begin
			r.control_type = CT_STOP;
		end else if (b4[7:6] == 2'b00) begin
			r.control_type = CT_PTZ;
			r.zoom_dir     = dir_code(b4[5:4]);
			r.tilt_dir     = dir_code(b4[3:2]);
			r.pan_dir      = dir_code(b4[1:0]);
			r.byte_five    = b5;
			r.byte_six     = b6;
			r.zoom_speed   = b7[7:4];
		end else if (b4[7:4] == B4_FI_NIBBLE) begin
			r.control_type = CT_FI;
			r.iris_dir     = dir_code(b4[3:2]);
			r.focus_dir    = dir_code(b4[1:0]);
			r.byte_five    = b5;
			r.byte_six     = b6;
		end else if (b4 >= B4_PRESET_LO && b4 <= B4_PRESET_HI) begin
			diff           = b4 - B4_PRESET_LO;
			r.control_type = CT_PRESET;
			r.sub_command  = diff[2:0];
			r.byte_six     = b6;
		end else if (b4 >= B4_PATROL_LO && b4 <= B4_PATROL_HI) begin
			diff             = b4 - B4_PATROL_LO;
			r.control_type   = CT_PATROL;
			r.sub_command    = diff[2:0];
			r.byte_five      = b5;
			r.byte_six       = b6;
			r.combined_value = comb;
		end else if (b4 == B4_SCAN || b4 == B4_SCAN_SPEED) begin
			r.control_type = CT_SCAN;
			if (b4 == B4_SCAN_SPEED) begin
				r.sub_command = SUB_SCAN_SPEED;
			end else if (b6 <= SCAN_SUB_MAX) begin
				r.sub_command = b6[2:0];
			end
			r.byte_five      = b5;
			r.byte_six       = b6;
			r.combined_value = comb;
		end else begin
			r.control_type = CT_UNKNOWN;
		end
		return r;
	endfunction

endpackage

// ----- design/pcfd_in_if.sv -----
// ----------------------------------------------------------------------------
// pcfd_in_if
// Byte channel into the frame decoder: valid, ready, frame byte and start mark.
// ----------------------------------------------------------------------------
interface pcfd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_start;

	modport source (output valid, output frame_byte, output frame_start, input ready);
	modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

// ----- design/pcfd_out_if.sv -----
// ----------------------------------------------------------------------------
// pcfd_out_if
// Decoded command channel out of the frame decoder.
// ----------------------------------------------------------------------------
interface pcfd_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  control_type;
	logic [1:0]  zoom_dir;
	logic [1:0]  tilt_dir;
	logic [1:0]  pan_dir;
	logic [1:0]  iris_dir;
	logic [1:0]  focus_dir;
	logic [2:0]  sub_command;
	logic [7:0]  byte_five;
	logic [7:0]  byte_six;
	logic [3:0]  zoom_speed;
	logic [11:0] combined_value;

	modport source (output valid, output control_type, output zoom_dir, output tilt_dir,
		output pan_dir, output iris_dir, output focus_dir, output sub_command,
		output byte_five, output byte_six, output zoom_speed, output combined_value,
		input ready);
	modport sink   (input valid, input control_type, input zoom_dir, input tilt_dir,
		input pan_dir, input iris_dir, input focus_dir, input sub_command,
		input byte_five, input byte_six, input zoom_speed, input combined_value,
		output ready);
endinterface

// ----- design/ptz_command_frame_decoder.sv -----
// A byte that ends a frame is held in the input register; its decoded command then loads into the result register.
// Throughput: one byte per cycle; the input register frees in the same cycle it passes on.
// The only stall is a full result register that the sink does not take.
// Reset: arst_n low clears the byte position and both valid flags; the kept bytes
// and the result payload are not reset.
// ----------------------------------------------------------------------------
// ptz_command_frame_decoder
// Tracks the byte position in the 8-byte PTZ control frame, keeps bytes 4 to 7
// and decodes them into one command transaction on the eighth byte.
// ----------------------------------------------------------------------------
module ptz_command_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	pcfd_in_if.sink     frame_in,
	pcfd_out_if.source  cmd_out
);

	// Input register: one accepted byte transaction.
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 start_s1;

	// Frame tracking state.
	logic [2:0]           pos_q;
	logic [7:0]           kept_q [4];

	// Result register.
	logic                 out_valid_q;
	pcfd_pkg::result_t    result_q;

	logic [2:0]           pos_cur;
	logic                 fire;
	logic                 out_free;
	logic                 adv;
	logic                 keep;
	logic [1:0]           keep_idx;
	pcfd_pkg::result_t    decoded;

	// A start mark forces byte 1 whatever the running position says.
	assign pos_cur  = start_s1 ? pcfd_pkg::POS_FIRST : pos_q;
	assign fire     = (pos_cur == pcfd_pkg::POS_LAST);
	assign out_free = !out_valid_q || cmd_out.ready;

	// Advance the held byte unless it ends a frame and the result register is stuck.
	assign adv            = valid_s1 && (!fire || out_free);
	assign frame_in.ready = !valid_s1 || adv;

	// Bytes 4..7 land in slots 0..3: slot = position - 3, mod 4.
	assign keep     = adv && (pos_cur >= pcfd_pkg::POS_B4) && (pos_cur <= pcfd_pkg::POS_B7);
	assign keep_idx = pos_cur[1:0] + 2'd1;

	// All four kept bytes are in place once the eighth byte sits in the input register.
	assign decoded = pcfd_pkg::decode(kept_q[0], kept_q[1], kept_q[2], kept_q[3]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	// Capture payload on every accepted transaction.
	always_ff @(posedge clk) begin
		if (frame_in.valid && frame_in.ready) begin
			byte_s1  <= frame_in.frame_byte;
			start_s1 <= frame_in.frame_start;
		end
	end

	// Position wraps from the eighth byte back to byte 1 on its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= pcfd_pkg::POS_FIRST;
		end else if (adv) begin
			pos_q <= pos_cur + 3'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (keep) begin
			kept_q[keep_idx] <= byte_s1;
		end
	end

	// Hold the result until taken; a new one may load in the same edge it leaves.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv && fire) begin
			out_valid_q <= 1'b1;
		end else if (cmd_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && fire) begin
			result_q <= decoded;
		end
	end

	assign cmd_out.valid          = out_valid_q;
	assign cmd_out.control_type   = result_q.control_type;
	assign cmd_out.zoom_dir       = result_q.zoom_dir;
	assign cmd_out.tilt_dir       = result_q.tilt_dir;
	assign cmd_out.pan_dir        = result_q.pan_dir;
	assign cmd_out.iris_dir       = result_q.iris_dir;
	assign cmd_out.focus_dir      = result_q.focus_dir;
	assign cmd_out.sub_command    = result_q.sub_command;
	assign cmd_out.byte_five      = result_q.byte_five;
	assign cmd_out.byte_six       = result_q.byte_six;
	assign cmd_out.zoom_speed     = result_q.zoom_speed;
	assign cmd_out.combined_value = result_q.combined_value;

endmodule

// ----- design/ptz_command_frame_decoder_chk.sv -----
// ----------------------------------------------------------------------------
// ptz_command_frame_decoder_chk
// Port-level checks of the frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "ptz_command_frame_decoder_assert.svh"

module ptz_command_frame_decoder_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [2:0]  control_type,
	input logic [1:0]  zoom_dir,
	input logic [1:0]  tilt_dir,
	input logic [1:0]  pan_dir,
	input logic [3:0]  zoom_speed,
	input logic [11:0] combined_value
);

	logic ptz_cmd;
	logic comb_cmd;
	logic out_stall;
	logic ptz_clear;
	logic in_fire;

	assign ptz_cmd   = (control_type == pcfd_pkg::CT_PTZ);
	assign comb_cmd  = (control_type == pcfd_pkg::CT_PATROL) ||
		(control_type == pcfd_pkg::CT_SCAN);
	assign out_stall = out_valid && !out_ready;
	assign ptz_clear = (zoom_dir == pcfd_pkg::DIR_NONE) && (tilt_dir == pcfd_pkg::DIR_NONE) &&
		(pan_dir == pcfd_pkg::DIR_NONE) && (zoom_speed == 4'd0);
	assign in_fire   = in_valid && in_ready;

	`PCFD_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")
	`PCFD_ASSERT_NEXT(a_out_stable, out_stall,
		$stable(control_type) && $stable(combined_value), "result changed while stalled")
	`PCFD_ASSERT_NOW(a_ptz_only, out_valid && !ptz_cmd, ptz_clear, "ptz fields set on another class")
	`PCFD_ASSERT_NOW(a_comb_only, out_valid && !comb_cmd, combined_value == 12'd0,
		"combined value set outside patrol or scan")
	`PCFD_ASSERT_NOW(a_rise_cause, $rose(out_valid), $past(in_fire, 2),
		"result with no byte transaction behind it")

endmodule

bind ptz_command_frame_decoder ptz_command_frame_decoder_chk u_chk (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (frame_in.valid),
	.in_ready       (frame_in.ready),
	.out_valid      (cmd_out.valid),
	.out_ready      (cmd_out.ready),
	.control_type   (cmd_out.control_type),
	.zoom_dir       (cmd_out.zoom_dir),
	.tilt_dir       (cmd_out.tilt_dir),
	.pan_dir        (cmd_out.pan_dir),
	.zoom_speed     (cmd_out.zoom_speed),
	.combined_value (cmd_out.combined_value)
);
